>>> rtl/lcg_rbr_pkg.sv
// shared constants, types and helpers of the bounded-range lcg unit
package lcg_rbr_pkg;

    // generator constants
    localparam logic [31:0] LCG_MULT = 32'd3332264781;
    localparam logic [31:0] LCG_INC  = 32'd907633385;
    localparam logic [31:0] SEED_RST = 32'd1;
    localparam int          WORD_W   = 32;
    localparam int          LIMIT_W  = 30;
    localparam int          NUM_W    = 31;
    localparam int          SHIFT_W  = 5;

    // register index of the seed
    localparam logic REG_SEED = 1'b0;

    // request kinds
    localparam logic KIND_PLAIN  = 1'b0;
    localparam logic KIND_SCALED = 1'b1;

    // operands of the shared multiply-add unit
    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
    } mul_op_t;

    // bit length of a range value 1 .. 2^30
    function automatic logic [SHIFT_W-1:0] bit_len(input logic [NUM_W-1:0] v);
        logic [SHIFT_W-1:0] n;
        n = '0;
        for (int i = 0; i < NUM_W; i++) begin
            if (v[i]) begin
                n = SHIFT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/lcg_rbr_mul.sv
// shared 32x32 multiply-add unit, low word of the result, registered
module lcg_rbr_mul (
    input  logic                aclk,
    input  lcg_rbr_pkg::mul_op_t op_i,
    output logic [31:0]         p_o
);
    import lcg_rbr_pkg::*;

    logic [2*WORD_W-1:0] full;
    logic [WORD_W-1:0]   p_reg;
    logic [WORD_W-1:0]   p_next;

    // product and addend, kept modulo 2^32
    assign full   = (2*WORD_W)'(op_i.a) * (2*WORD_W)'(op_i.b);
    assign p_next = full[WORD_W-1:0] + op_i.c;

    // result register
    always_ff @(posedge aclk) begin
        if (op_i.en) begin
            p_reg <= p_next;
        end
    end

    assign p_o = p_reg;

endmodule

>>> rtl/lcg_random_with_bounded_range_unit.sv
// top level of the bounded-range lcg unit: sequencer, state and ports
//
// Usage:
//   Input stream (s_*): one request per transfer. s_tuser is the kind
//   (0 = plain 31-bit number, 1 = number scaled into 0..limit) and
//   s_tdata[29:0] the inclusive limit. Output stream (m_*): one number per
//   request in m_tdata[30:0], in request order.
//   The APB port holds the seed register at address 0; a write loads the
//   generator state, a read returns the last seed written (1 after reset).
//   Sequence: a plain request steps through ADV, STORE and DONE, a scaled
//   one through ADV, STORE, SCALE and DONE; DONE loads the output register
//   and the next request is taken only once the state is back in IDLE. The
//   pace is set by the single shared multiply-add unit, used once to advance
//   the state and once to scale a scaled number, with its registered product.
//   Reset (aresetn low, synchronous) sets the state and seed to 1 and
//   empties the output register. A stalled receiver holds the result in
//   the output register; one more request is taken and computed, then
//   waits until the output register frees.
module lcg_random_with_bounded_range_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [29:0] limit, [31:30] zero
    input  logic [0:0]  s_tuser,   // [0] kind
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] number, [31] zero
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcg_rbr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_STORE,
        ST_SCALE,
        ST_DONE
    } state_t;

    state_t             state_reg,  state_next;
    logic [WORD_W-1:0]  gen_reg,    gen_next;
    logic [WORD_W-1:0]  seed_reg,   seed_next;
    logic               kind_reg,   kind_next;
    logic [NUM_W-1:0]   range_reg,  range_next;
    logic [SHIFT_W-1:0] sh_reg,     sh_next;
    logic [NUM_W-1:0]   res_reg,    res_next;
    logic               mval_reg,   mval_next;
    logic [NUM_W-1:0]   mnum_reg,   mnum_next;

    mul_op_t            mul_op;
    logic [WORD_W-1:0]  mul_p;
    logic [NUM_W-1:0]   range_in;
    logic               cfg_wr;

    lcg_rbr_mul u_mul (
        .aclk (aclk),
        .op_i (mul_op),
        .p_o  (mul_p)
    );

    // configuration access
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_SEED);
    assign prdata   = (paddr[2] == REG_SEED) ? seed_reg : '0;

    // range of an incoming request, the limit plus one
    assign range_in = NUM_W'(s_tdata[LIMIT_W-1:0]) + NUM_W'(1);

    // multiplier operands per step
    always_comb begin
        mul_op = '0;
        unique case (state_reg)
            ST_ADV: begin
                mul_op.en = 1'b1;
                mul_op.a  = gen_reg;
                mul_op.b  = LCG_MULT;
                mul_op.c  = LCG_INC;
            end
            ST_STORE: begin
                mul_op.en = (kind_reg == KIND_SCALED);
                mul_op.a  = mul_p >> sh_reg;
                mul_op.b  = WORD_W'(range_reg);
            end
            default: begin
                mul_op = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        gen_next   = gen_reg;
        seed_next  = seed_reg;
        kind_next  = kind_reg;
        range_next = range_reg;
        sh_next    = sh_reg;
        res_next   = res_reg;
        mval_next  = mval_reg;
        mnum_next  = mnum_reg;

        // output register drains
        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_tuser[0];
                    range_next = range_in;
                    sh_next    = bit_len(range_in);
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                state_next = ST_STORE;
            end
            ST_STORE: begin
                gen_next = mul_p;
                if (kind_reg == KIND_PLAIN) begin
                    res_next   = mul_p[WORD_W-1:1];
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                res_next   = NUM_W'(mul_p >> (6'd32 - {1'b0, sh_reg}));
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mnum_next  = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // seed write loads the generator
        if (cfg_wr) begin
            seed_next = pwdata;
            gen_next  = pwdata;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gen_reg   <= SEED_RST;
            seed_reg  <= SEED_RST;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
            seed_reg  <= seed_next;
            mval_reg  <= mval_next;
        end
        kind_reg  <= kind_next;
        range_reg <= range_next;
        sh_reg    <= sh_next;
        res_reg   <= res_next;
        mnum_reg  <= mnum_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = {1'b0, mnum_reg};

endmodule

>>> rtl/lcg_rbr_chk.sv
// port-level checks of the bounded-range lcg unit and their binding
module lcg_rbr_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        pready
);
    // a stalled result holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output transfer changed");

    // one request at a time: busy right after a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // the input is not yet ready again when the request reaches its store step
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 !s_tready)
        else $error("input ready too early after a transfer");

    // results are 31-bit numbers
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31] == 1'b0)
        else $error("output number exceeds 31 bits");

    // configuration port never waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("configuration port not ready");

endmodule

bind lcg_random_with_bounded_range_unit lcg_rbr_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
